// ===== rtl/tcrd_pkg.sv =====
package tcrd_pkg;

    localparam int ADDR_BITS    = 24;
    localparam int SUBPAGE_BITS = 16;
    localparam int WORD_BITS    = 16;
    localparam int COUNT_BITS   = 16;
    localparam int STRIDE_BITS  = 16;
    localparam int SLOT_BITS    = 5;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [SLOT_BITS-1:0] SLOT_STEP     = 5'd2;
    localparam logic [SLOT_BITS-1:0] SECOND_OFFSET = 5'd16;
    localparam logic [SLOT_BITS-1:0] RD_SLOT_A     = 5'd2;
    localparam logic [SLOT_BITS-1:0] WR_SLOT_A     = 5'd6;
    localparam logic [SLOT_BITS-1:0] RD_SLOT_B     = 5'd10;
    localparam logic [SLOT_BITS-1:0] WR_SLOT_B     = 5'd14;

    typedef struct packed {
        logic                   func;
        logic                   channel;
        logic [ADDR_BITS-1:0]   src_addr;
        logic [ADDR_BITS-1:0]   dst_addr;
        logic [COUNT_BITS-1:0]  row_width;
        logic [COUNT_BITS-1:0]  word_count;
        logic [STRIDE_BITS-1:0] src_stride;
        logic [STRIDE_BITS-1:0] dst_stride;
        logic                   vram_mode;
        logic [WORD_BITS-1:0]   read_data;
    } t_in_item;

    typedef struct packed {
        logic                 rd_valid;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_valid;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 irq_a;
        logic                 irq_b;
        logic                 run_a;
        logic                 run_b;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  width;
        logic [COUNT_BITS-1:0]  size;
        logic [STRIDE_BITS-1:0] sstride;
        logic [STRIDE_BITS-1:0] dstride;
        logic                   vram;
    } t_desc;

    function automatic logic [ADDR_BITS-1:0] subpage_add(
        input logic [ADDR_BITS-1:0]   ptr,
        input logic [STRIDE_BITS-1:0] amount
    );
        logic [SUBPAGE_BITS-1:0] low;
        low = ptr[SUBPAGE_BITS-1:0] + SUBPAGE_BITS'(amount);
        return {ptr[ADDR_BITS-1:SUBPAGE_BITS], low};
    endfunction

endpackage

// ===== rtl/two_channel_rect_dma_unit.sv =====
// The result of an input transfer is registered and offered in the cycle after the input is accepted.
// Throughput: one item per cycle; the result register is loaded whenever it is
// empty or its content is taken in the same cycle.
// Reset (synchronous, active low) stops both channels, clears the slot counter,
// the word and column counters, the outstanding-read flags and the result valid.
module two_channel_rect_dma_unit
    import tcrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [SLOT_BITS-1:0]  r_slot,      n_slot;
    logic [1:0]            r_run,       n_run;
    logic [1:0]            r_pend,      n_pend;
    logic [ADDR_BITS-1:0]  r_src [2],   n_src [2];
    logic [ADDR_BITS-1:0]  r_dst [2],   n_dst [2];
    logic [WORD_BITS-1:0]  r_buf [2],   n_buf [2];
    logic [COUNT_BITS-1:0] r_done [2],  n_done [2];
    logic [COUNT_BITS-1:0] r_col [2],   n_col [2];
    t_desc                 r_desc [2],  n_desc [2];
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out,       n_out;

    logic accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [SLOT_BITS-1:0]  rd_slot;
        logic [SLOT_BITS-1:0]  wr_slot;
        logic                  second;
        logic                  rd_hit;
        logic                  wr_hit;
        logic [COUNT_BITS-1:0] done_inc;
        logic [COUNT_BITS-1:0] col_inc;
        logic [1:0]            irq;

        n_slot   = r_slot;
        n_run    = r_run;
        n_pend   = r_pend;
        n_src    = r_src;
        n_dst    = r_dst;
        n_buf    = r_buf;
        n_done   = r_done;
        n_col    = r_col;
        n_desc   = r_desc;
        n_out    = '0;
        irq      = '0;
        rd_slot  = '0;
        wr_slot  = '0;
        second   = 1'b0;
        rd_hit   = 1'b0;
        wr_hit   = 1'b0;
        done_inc = '0;
        col_inc  = '0;

        if (accept) begin
            if (i_in_data.func == FUNC_START) begin
                n_src[i_in_data.channel]          = i_in_data.src_addr;
                n_dst[i_in_data.channel]          = i_in_data.dst_addr;
                n_desc[i_in_data.channel].width   = i_in_data.row_width;
                n_desc[i_in_data.channel].size    = i_in_data.word_count;
                n_desc[i_in_data.channel].sstride = i_in_data.src_stride;
                n_desc[i_in_data.channel].dstride = i_in_data.dst_stride;
                n_desc[i_in_data.channel].vram    = i_in_data.vram_mode;
                n_done[i_in_data.channel]         = '0;
                n_col[i_in_data.channel]          = '0;
                n_run[i_in_data.channel]          = 1'b1;
            end else begin
                for (int c = 0; c < 2; c++) begin
                    if (r_pend[c]) begin
                        n_buf[c] = i_in_data.read_data;
                    end
                end
                n_pend = '0;

                for (int c = 0; c < 2; c++) begin
                    rd_slot  = (c == 0) ? RD_SLOT_A : RD_SLOT_B;
                    wr_slot  = (c == 0) ? WR_SLOT_A : WR_SLOT_B;
                    second   = !r_desc[c].vram;
                    rd_hit   = (r_slot == rd_slot)
                            || (second && (r_slot == rd_slot + SECOND_OFFSET));
                    wr_hit   = (r_slot == wr_slot)
                            || (second && (r_slot == wr_slot + SECOND_OFFSET));
                    done_inc = r_done[c] + COUNT_BITS'(1);
                    col_inc  = r_col[c] + COUNT_BITS'(1);
                    if (r_run[c]) begin
                        if (rd_hit) begin
                            n_out.rd_valid = 1'b1;
                            n_out.rd_addr  = r_src[c];
                            n_src[c]       = subpage_add(r_src[c], STRIDE_BITS'(1));
                            n_pend[c]      = 1'b1;
                        end else if (wr_hit) begin
                            n_out.wr_valid = 1'b1;
                            n_out.wr_addr  = r_dst[c];
                            n_out.wr_data  = n_buf[c];
                            n_done[c]      = done_inc;
                            n_col[c]       = col_inc;
                            if (done_inc == r_desc[c].size) begin
                                n_done[c] = '0;
                                n_run[c]  = 1'b0;
                                irq[c]    = 1'b1;
                            end
                            if (col_inc == r_desc[c].width) begin
                                n_col[c] = '0;
                                n_src[c] = subpage_add(r_src[c], r_desc[c].sstride);
                                n_dst[c] = subpage_add(r_dst[c],
                                                       r_desc[c].dstride + STRIDE_BITS'(1));
                            end else begin
                                n_dst[c] = subpage_add(r_dst[c], STRIDE_BITS'(1));
                            end
                        end
                    end
                end
                n_slot = r_slot + SLOT_STEP;
            end
        end

        n_out.irq_a = irq[0];
        n_out.irq_b = irq[1];
        n_out.run_a = n_run[0];
        n_out.run_b = n_run[1];
    end

    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_run       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_done[c] <= '0;
                r_col[c]  <= '0;
            end
        end else begin
            r_slot      <= n_slot;
            r_run       <= n_run;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
            r_col       <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_buf  <= n_buf;
        r_desc <= n_desc;
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== tb/rect_dma_checker.sv =====
module rect_dma_checker
    import tcrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_waiting
);

    localparam logic [ADDR_BITS-1:0] LOW_MASK = ADDR_BITS'((64'd1 << SUBPAGE_BITS) - 1);

    logic [SLOT_BITS-1:0]  cur_slot;
    logic [1:0]            chan_running;
    logic [1:0]            read_owed;
    logic [ADDR_BITS-1:0]  src_ptr [2];
    logic [ADDR_BITS-1:0]  dst_ptr [2];
    logic [WORD_BITS-1:0]  word_buf [2];
    logic [COUNT_BITS-1:0] words_done [2];
    logic [COUNT_BITS-1:0] col_pos [2];
    t_desc                 chan_desc [2];
    t_out_item             bus_cycles_due [$];

    function automatic logic [ADDR_BITS-1:0] step_in_page(
        input logic [ADDR_BITS-1:0]   ptr,
        input logic [STRIDE_BITS-1:0] amount
    );
        logic [ADDR_BITS-1:0] sum;
        sum = ptr + ADDR_BITS'(amount);
        return (ptr & ~LOW_MASK) | (sum & LOW_MASK);
    endfunction

    task automatic model_bus_cycle(input t_in_item it, output t_out_item res);
        logic [SLOT_BITS-1:0] rd_at;
        logic [SLOT_BITS-1:0] wr_at;
        logic                 both_pairs;
        res = '0;
        if (it.func == FUNC_START) begin
            src_ptr[it.channel]      = it.src_addr;
            dst_ptr[it.channel]      = it.dst_addr;
            chan_desc[it.channel]    = '{width: it.row_width, size: it.word_count,
                                         sstride: it.src_stride, dstride: it.dst_stride,
                                         vram: it.vram_mode};
            words_done[it.channel]   = '0;
            col_pos[it.channel]      = '0;
            chan_running[it.channel] = 1'b1;
        end else begin
            for (int c = 0; c < 2; c++) begin
                if (read_owed[c]) begin
                    word_buf[c] = it.read_data;
                end
            end
            read_owed = '0;
            for (int c = 0; c < 2; c++) begin
                rd_at      = (c == 1) ? RD_SLOT_B : RD_SLOT_A;
                wr_at      = (c == 1) ? WR_SLOT_B : WR_SLOT_A;
                both_pairs = !chan_desc[c].vram;
                if (chan_running[c]) begin
                    if (cur_slot == rd_at || (both_pairs && cur_slot == rd_at + SECOND_OFFSET)) begin
                        res.rd_valid = 1'b1;
                        res.rd_addr  = src_ptr[c];
                        src_ptr[c]   = step_in_page(src_ptr[c], STRIDE_BITS'(1));
                        read_owed[c] = 1'b1;
                    end else if (cur_slot == wr_at ||
                                 (both_pairs && cur_slot == wr_at + SECOND_OFFSET)) begin
                        res.wr_valid  = 1'b1;
                        res.wr_addr   = dst_ptr[c];
                        res.wr_data   = word_buf[c];
                        dst_ptr[c]    = step_in_page(dst_ptr[c], STRIDE_BITS'(1));
                        col_pos[c]    = col_pos[c] + 1'b1;
                        words_done[c] = words_done[c] + 1'b1;
                        if (words_done[c] == chan_desc[c].size) begin
                            words_done[c]   = '0;
                            chan_running[c] = 1'b0;
                            if (c == 1) begin
                                res.irq_b = 1'b1;
                            end else begin
                                res.irq_a = 1'b1;
                            end
                        end
                        if (col_pos[c] == chan_desc[c].width) begin
                            col_pos[c] = '0;
                            src_ptr[c] = step_in_page(src_ptr[c], chan_desc[c].sstride);
                            dst_ptr[c] = step_in_page(dst_ptr[c], chan_desc[c].dstride);
                        end
                    end
                end
            end
            cur_slot = cur_slot + SLOT_STEP;
        end
        res.run_a = chan_running[0];
        res.run_b = chan_running[1];
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t rect_dma_checker: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item oldest;
        if (!i_rst_n) begin
            cur_slot     = '0;
            chan_running = '0;
            read_owed    = '0;
            for (int c = 0; c < 2; c++) begin
                src_ptr[c]    = '0;
                dst_ptr[c]    = '0;
                word_buf[c]   = '0;
                words_done[c] = '0;
                col_pos[c]    = '0;
                chan_desc[c]  = '0;
            end
            bus_cycles_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                model_bus_cycle(i_in_data, predicted);
                bus_cycles_due.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (bus_cycles_due.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    oldest = bus_cycles_due.pop_front();
                    compare_field("rd_valid", 32'(i_out_data.rd_valid), 32'(oldest.rd_valid));
                    compare_field("rd_addr", 32'(i_out_data.rd_addr), 32'(oldest.rd_addr));
                    compare_field("wr_valid", 32'(i_out_data.wr_valid), 32'(oldest.wr_valid));
                    compare_field("wr_addr", 32'(i_out_data.wr_addr), 32'(oldest.wr_addr));
                    compare_field("wr_data", 32'(i_out_data.wr_data), 32'(oldest.wr_data));
                    compare_field("irq_a", 32'(i_out_data.irq_a), 32'(oldest.irq_a));
                    compare_field("irq_b", 32'(i_out_data.irq_b), 32'(oldest.irq_b));
                    compare_field("run_a", 32'(i_out_data.run_a), 32'(oldest.run_a));
                    compare_field("run_b", 32'(i_out_data.run_b), 32'(oldest.run_b));
                end
            end
        end
        o_waiting = bus_cycles_due.size();
    end

endmodule

// ===== tb/tb_two_channel_rect_dma_unit.sv =====
module tb_two_channel_rect_dma_unit;
    import tcrd_pkg::*;

    localparam int   RANDOM_ITEMS = 1700;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   HOLD_CYCLES  = 80;
    localparam int   HOLD_AT      = 400;
    localparam int   CALM_FIRST   = 700;
    localparam int   CALM_LAST    = 1000;
    localparam int   DRAIN_CYCLES = 8;
    localparam logic CH_A         = 1'b0;
    localparam logic CH_B         = 1'b1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        waiting;
    int        sent      = 0;
    int        cycles    = 0;
    int        hold_left = 0;
    bit        held      = 1'b0;
    bit        calm      = 1'b0;

    always #6 clk = ~clk;

    two_channel_rect_dma_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rect_dma_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_two_channel_rect_dma_unit: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!held && sent >= HOLD_AT) begin
            held      <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 30);
        end
    end

    function automatic t_in_item tick_item();
        t_in_item     it;
        logic [159:0] raw;
        raw     = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it      = raw[$bits(t_in_item)-1:0];
        it.func = FUNC_TICK;
        return it;
    endfunction

    function automatic t_in_item start_item(
        input logic                   ch,
        input logic [ADDR_BITS-1:0]   src,
        input logic [ADDR_BITS-1:0]   dst,
        input logic [COUNT_BITS-1:0]  row_w,
        input logic [COUNT_BITS-1:0]  total,
        input logic [STRIDE_BITS-1:0] s_step,
        input logic [STRIDE_BITS-1:0] d_step,
        input logic                   vm
    );
        t_in_item it;
        it            = tick_item();
        it.func       = FUNC_START;
        it.channel    = ch;
        it.src_addr   = src;
        it.dst_addr   = dst;
        it.row_width  = row_w;
        it.word_count = total;
        it.src_stride = s_step;
        it.dst_stride = d_step;
        it.vram_mode  = vm;
        return it;
    endfunction

    function automatic t_in_item random_start();
        t_in_item it;
        it      = tick_item();
        it.func = FUNC_START;
        if ($urandom_range(99) < 80) begin
            it.row_width  = COUNT_BITS'($urandom_range(1, 4));
            it.word_count = COUNT_BITS'($urandom_range(1, 8));
            if ($urandom_range(1) == 1) begin
                it.src_addr[SUBPAGE_BITS-1:0] = {SUBPAGE_BITS{1'b1}} -
                                                SUBPAGE_BITS'($urandom_range(3));
            end
            if ($urandom_range(1) == 1) begin
                it.dst_addr[SUBPAGE_BITS-1:0] = {SUBPAGE_BITS{1'b1}} -
                                                SUBPAGE_BITS'($urandom_range(3));
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        calm = (sent >= CALM_FIRST && sent < CALM_LAST);
        while (!calm && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start both channels at slot 0 so each reads before its first write
        send_item(start_item(CH_A, 24'h00FFFE, 24'hFFFFFF, 16'd3, 16'd5,
                             16'hFFFF, 16'h0001, 1'b0));
        send_item(start_item(CH_B, 24'hABFFF0, 24'h000000, 16'd1, 16'd1,
                             16'h0010, 16'hFFF0, 1'b1));
        repeat (2) send_item(tick_item());
        // restart A between its read and the tick that returns the data
        send_item(start_item(CH_A, 24'h12FFFF, 24'h34FFFE, 16'd2, 16'd3,
                             16'h0003, 16'h0002, 1'b0));
        repeat (10) send_item(tick_item());
        send_item(start_item(CH_B, {ADDR_BITS{1'b1}}, {ADDR_BITS{1'b1}},
                             {COUNT_BITS{1'b1}}, {COUNT_BITS{1'b1}},
                             {STRIDE_BITS{1'b1}}, {STRIDE_BITS{1'b1}}, 1'b1));
        send_item(start_item(CH_A, '0, '0, '0, '0, '0, '0, 1'b0));
        repeat (6) send_item(tick_item());

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(99) < 4) begin
                send_item(random_start());
            end else begin
                send_item(tick_item());
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("tb_two_channel_rect_dma_unit: PASS");
        end else begin
            $display("tb_two_channel_rect_dma_unit: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcrd_pkg.sv
rtl/two_channel_rect_dma_unit.sv
tb/rect_dma_checker.sv
tb/tb_two_channel_rect_dma_unit.sv
